>>> rtl/spsl_pkg.sv
// ----------------------------------------------------------------------------
// spsl_pkg
// Shared types and constants of the stable priority sorted list.
// ----------------------------------------------------------------------------
package spsl_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int COUNT_W    = $clog2(LIST_DEPTH + 1);
	localparam int HELD_W     = 7;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_DUMP   = 2'd2,
		ACT_COUNT  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_COUNT = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] priority_req;
		logic [15:0]        object_tag;
		logic [7:0]         routine_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] entry_priority_out;
		logic [15:0]        entry_object_out;
		logic [7:0]         entry_routine_out;
		logic [HELD_W-1:0]  held_count;
		logic               status;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] pri;
		logic [15:0]        obj;
		logic [7:0]         rtn;
	} slot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  latch_req;
		logic  ptr_clear;
		logic  ptr_inc;
		logic  insert;
		logic  rm_step;
		logic  rm_commit;
		logic  out_load;
		kind_t out_kind;
		logic  out_status;
		logic  out_last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic ptr_at_end;
		logic ptr_is_last;
	} stat_t;

endpackage

>>> rtl/spsl_datapath.sv
// ----------------------------------------------------------------------------
// spsl_datapath
// Slot registers, entry count, walk pointers and the response register.
// ----------------------------------------------------------------------------
module spsl_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  spsl_pkg::req_t  req,
	input  spsl_pkg::cmd_t  cmd,
	output spsl_pkg::stat_t st,
	output spsl_pkg::rsp_t  rsp
);
	import spsl_pkg::*;

	slot_t              slot_q [LIST_DEPTH];
	slot_t              slot_d [LIST_DEPTH];
	slot_t              shift_in [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] lte;
	logic [LIST_DEPTH-1:0] lte_prev;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] ptr_q;
	logic [COUNT_W-1:0] wr_q;
	req_t               req_q;
	rsp_t               rsp_q;
	slot_t              new_slot;
	slot_t              cur_slot;
	logic               cur_match;

	assign new_slot  = '{pri: req_q.priority_req, obj: req_q.object_tag, rtn: req_q.routine_tag};
	assign cur_slot  = slot_q[ptr_q[IDX_W-1:0]];
	assign cur_match = (cur_slot.pri == req_q.priority_req) &&
		(cur_slot.obj == req_q.object_tag) && (cur_slot.rtn == req_q.routine_tag);

	// Since the list is sorted, lte is a run of ones from slot zero; the new
	// entry lands in the first slot that is clear and the rest move up by one.
	genvar g;
	for (g = 0; g < LIST_DEPTH; g++) begin : g_slot
		assign lte[g] = (COUNT_W'(g) < count_q) && (slot_q[g].pri <= req_q.priority_req);
		if (g == 0) begin : g_first
			assign lte_prev[g] = 1'b1;
			assign shift_in[g] = new_slot;
		end else begin : g_rest
			assign lte_prev[g] = lte[g-1];
			assign shift_in[g] = slot_q[g-1];
		end
	end

	always_comb begin
		for (int j = 0; j < LIST_DEPTH; j++) begin
			slot_d[j] = slot_q[j];
			if (cmd.insert && !lte[j]) begin
				slot_d[j] = lte_prev[j] ? new_slot : shift_in[j];
			end
		end
		if (cmd.rm_step && !cur_match) begin
			slot_d[wr_q[IDX_W-1:0]] = cur_slot;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < LIST_DEPTH; j++) begin
			slot_q[j] <= slot_d[j];
		end
		if (cmd.latch_req) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			wr_q    <= '0;
		end else begin
			if (cmd.ptr_clear) begin
				ptr_q <= '0;
				wr_q  <= '0;
			end else begin
				if (cmd.ptr_inc || cmd.rm_step) begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (cmd.rm_step && !cur_match) begin
					wr_q <= wr_q + 1'b1;
				end
			end
			if (cmd.insert) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.rm_commit) begin
				count_q <= wr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.kind       <= cmd.out_kind;
			rsp_q.held_count <= HELD_W'(count_q);
			rsp_q.status     <= cmd.out_status;
			rsp_q.last       <= cmd.out_last;
			if (cmd.out_kind == KIND_ENTRY) begin
				rsp_q.entry_priority_out <= cur_slot.pri;
				rsp_q.entry_object_out   <= cur_slot.obj;
				rsp_q.entry_routine_out  <= cur_slot.rtn;
			end else begin
				rsp_q.entry_priority_out <= '0;
				rsp_q.entry_object_out   <= '0;
				rsp_q.entry_routine_out  <= '0;
			end
		end
	end

	assign rsp = rsp_q;

	assign st.empty       = (count_q == '0);
	assign st.full        = (count_q == COUNT_W'(LIST_DEPTH));
	assign st.ptr_at_end  = (ptr_q == count_q);
	assign st.ptr_is_last = ((ptr_q + 1'b1) == count_q);

endmodule

>>> rtl/spsl_ctrl.sv
// ----------------------------------------------------------------------------
// spsl_ctrl
// Controller: sequences insert, remove walk, dump and the single reply.
// ----------------------------------------------------------------------------
module spsl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [1:0]      req_action,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  spsl_pkg::stat_t st,
	output spsl_pkg::cmd_t  cmd
);
	import spsl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_REMOVE,
		S_DUMP,
		S_REPLY
	} state_t;

	state_t state_q;
	kind_t  kind_q;
	logic   status_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.out_kind   = kind_q;
		cmd.out_status = status_q;
		cmd.out_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch_req = req_valid;
				cmd.ptr_clear = req_valid;
			end
			S_INSERT: begin
				cmd.insert = !st.full;
			end
			S_REMOVE: begin
				cmd.rm_step   = !st.ptr_at_end;
				cmd.rm_commit = st.ptr_at_end;
			end
			S_DUMP: begin
				cmd.out_load = out_free;
				cmd.ptr_inc  = out_free;
				cmd.out_kind = KIND_ENTRY;
				cmd.out_last = st.ptr_is_last;
			end
			S_REPLY: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= KIND_ACK;
			status_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						status_q <= 1'b0;
						unique case (req_action)
							ACT_INSERT: begin
								kind_q  <= KIND_ACK;
								state_q <= S_INSERT;
							end
							ACT_REMOVE: begin
								kind_q  <= KIND_ACK;
								state_q <= S_REMOVE;
							end
							ACT_DUMP: begin
								kind_q  <= KIND_EMPTY;
								state_q <= st.empty ? S_REPLY : S_DUMP;
							end
							ACT_COUNT: begin
								kind_q  <= KIND_COUNT;
								state_q <= S_REPLY;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_INSERT: begin
					status_q <= st.full;
					state_q  <= S_REPLY;
				end
				S_REMOVE: begin
					if (st.ptr_at_end) begin
						state_q <= S_REPLY;
					end
				end
				S_DUMP: begin
					if (out_free && st.ptr_is_last) begin
						state_q <= S_IDLE;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/stable_priority_sorted_list_top.sv
// ----------------------------------------------------------------------------
// stable_priority_sorted_list_top
// Bounded list of (priority, object, routine) entries kept in stable
// ascending priority order, with insert, remove, dump and count requests.
//
//   Channel  Signals                        Direction  Payload
//   req      req_valid, req_ready, req      in         spsl_pkg::req_t
//   rsp      rsp_valid, rsp_ready, rsp      out        spsl_pkg::rsp_t
//
// Insert goes through S_INSERT to S_REPLY; count and empty dump go to S_REPLY.
// Remove walks the held entries one per cycle, then commits and replies.
// A dump gives one entry per cycle while the response side keeps up.
// One request is worked at a time; a stalled response holds the controller.
// Reset empties the list at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
module stable_priority_sorted_list_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  spsl_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output spsl_pkg::rsp_t  rsp
);
	import spsl_pkg::*;

	cmd_t  cmd;
	stat_t st;

	spsl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_action (req.action),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.st         (st),
		.cmd        (cmd)
	);

	spsl_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.rsp    (rsp)
	);

endmodule
